@@ sv/ic_pkg.sv @@
// ----------------------------------------------------------------------------
// ic_pkg
// shared types and constants of the inclinometer conditioning block
// ----------------------------------------------------------------------------
package ic_pkg;

    localparam int FRAC_BITS = 8;
    localparam int NUM_W     = 64;
    localparam int DEN_W     = 32;
    localparam int ITER_W    = 7;
    localparam int FILT_W    = 40;
    localparam int FNUM_W    = 44;
    localparam int TEMP_REF  = 250;
    localparam int RECIP_10  = 52429;
    localparam int RECIP_SH  = 19;

    // floor(x / 1000) = (x * RECIP_1000) >> RECIP_1000_SH for 32-bit x
    localparam logic [31:0] RECIP_1000    = 32'd2199023256;
    localparam int          RECIP_1000_SH = 41;

    localparam logic [1:0] ACT_TICK      = 2'd0;
    localparam logic [1:0] ACT_CAL_START = 2'd1;
    localparam logic [1:0] ACT_LOAD      = 2'd2;

    typedef enum logic [2:0] {
        REG_FILTER_STRENGTH,
        REG_GAIN_X,
        REG_GAIN_Y,
        REG_ALARM_LOW_X,
        REG_ALARM_HIGH_X,
        REG_ALARM_LOW_Y,
        REG_ALARM_HIGH_Y,
        REG_TEMP_COMP_ENABLE
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIV_CAL,
        DIV_FLT,
        DIV_GAIN
    } t_div_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_CAL_GO,
        ST_CAL_WAIT,
        ST_FLT_GO,
        ST_FLT_WAIT,
        ST_MUL,
        ST_GAIN_GO,
        ST_GAIN_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] raw_x;
        logic signed [31:0] raw_y;
        logic signed [15:0] temperature;
        logic [31:0]        elapsed_ns;
    } t_req;

    typedef struct packed {
        logic signed [31:0] tilt_x;
        logic signed [31:0] tilt_y;
        logic               alarm_x;
        logic               alarm_y;
        logic               calibrating;
    } t_rsp;

    typedef struct packed {
        logic    clr;
        logic    acc;
        logic    load;
        logic    go;
        t_div_op op;
        logic    mul;
    } t_lane_cmd;

endpackage

@@ sv/ic_div.sv @@
// ----------------------------------------------------------------------------
// ic_div
// restoring unsigned divider, one quotient bit per cycle, numerator msb first
// ----------------------------------------------------------------------------
module ic_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [ic_pkg::NUM_W-1:0] i_num,
    input  logic [ic_pkg::DEN_W-1:0] i_den,
    input  logic [ic_pkg::ITER_W-1:0] i_iters,
    output logic                     o_done,
    output logic [ic_pkg::NUM_W-1:0] o_quo
);
    import ic_pkg::*;

    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [ITER_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DEN_W:0]    w_sh;
    logic [DEN_W:0]    w_sub;
    logic              w_ge;

    assign w_sh  = {r_rem, r_num[NUM_W-1]};
    assign w_ge  = (w_sh >= {1'b0, r_den});
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_iters;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == ITER_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_sub[DEN_W-1:0] : w_sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

@@ sv/ic_lane.sv @@
// ----------------------------------------------------------------------------
// ic_lane
// one axis: calibration sum, filter, offset and gain, compensation, alarm
// ----------------------------------------------------------------------------
module ic_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ic_pkg::t_lane_cmd  i_cmd,
    input  logic signed [31:0] i_raw,
    input  logic [2:0]         i_k,
    input  logic signed [31:0] i_gain,
    input  logic [31:0]        i_count,
    input  logic signed [31:0] i_comp,
    input  logic signed [31:0] i_alarm_lo,
    input  logic signed [31:0] i_alarm_hi,
    output logic               o_done,
    output logic signed [31:0] o_tilt,
    output logic               o_alarm
);
    import ic_pkg::*;

    logic signed [63:0]       r_sum;
    logic signed [31:0]       r_offset;
    logic signed [FILT_W-1:0] r_filt;
    logic signed [31:0]       r_v;
    logic signed [31:0]       r_prod;
    logic signed [31:0]       r_tilt;
    logic                     r_neg;
    t_div_op                  r_op;
    logic [63:0]              r_gmul;
    logic                     r_gdone;

    logic signed [FNUM_W-1:0] w_fnum;
    logic [FNUM_W-1:0]        w_fmag;
    logic [63:0]              w_smag;
    logic [31:0]              w_pmag;
    logic [NUM_W-1:0]         w_num;
    logic [DEN_W-1:0]         w_den;
    logic [ITER_W-1:0]        w_iters;
    logic                     w_neg;
    logic                     w_start;
    logic                     w_done;
    logic [NUM_W-1:0]         w_quo;
    logic signed [FILT_W-1:0] w_fnew;
    logic signed [FILT_W-1:0] w_fadj;
    logic [31:0]              w_gq;
    logic signed [31:0]       w_tilt;

    assign w_fnum = FNUM_W'(signed'({i_raw, FRAC_BITS'(0)}))
                  + FNUM_W'($signed({1'b0, i_k}) * r_filt);
    assign w_fmag = w_fnum[FNUM_W-1] ? -w_fnum : w_fnum;
    assign w_smag = r_sum[63] ? -r_sum : r_sum;
    assign w_pmag = r_prod[31] ? -r_prod : r_prod;

    always_comb begin
        unique case (i_cmd.op)
            DIV_CAL: begin
                w_neg   = r_sum[63];
                w_num   = w_smag;
                w_den   = i_count;
                w_iters = ITER_W'(NUM_W);
            end
            DIV_FLT: begin
                w_neg   = w_fnum[FNUM_W-1];
                w_num   = {w_fmag, (NUM_W-FNUM_W)'(0)};
                w_den   = DEN_W'({1'b0, i_k} + 4'd1);
                w_iters = ITER_W'(FNUM_W);
            end
            DIV_GAIN: begin
                w_neg   = r_prod[31];
                w_num   = '0;
                w_den   = DEN_W'(1);
                w_iters = ITER_W'(1);
            end
            default: begin
                w_neg   = 1'b0;
                w_num   = '0;
                w_den   = DEN_W'(1);
                w_iters = ITER_W'(1);
            end
        endcase
    end

    // division by 1000 is a reciprocal multiply, the divider is not started
    assign w_start = i_cmd.go && (i_cmd.op != DIV_GAIN);

    ic_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_iters (w_iters),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    assign w_fnew = r_neg ? -signed'(w_quo[FILT_W-1:0]) : signed'(w_quo[FILT_W-1:0]);
    assign w_fadj = w_fnew + (r_neg ? FILT_W'((1 << FRAC_BITS) - 1) : FILT_W'(0));
    assign w_gq   = 32'(r_gmul[63:RECIP_1000_SH]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_offset <= '0;
            r_filt   <= '0;
            r_gdone  <= 1'b0;
        end else begin
            r_gdone <= i_cmd.go && (i_cmd.op == DIV_GAIN);
            if (i_cmd.clr) begin
                r_sum <= '0;
            end else if (i_cmd.acc) begin
                r_sum <= r_sum + 64'(i_raw);
            end
            if (i_cmd.load) begin
                r_offset <= i_raw;
            end else if (w_done && r_op == DIV_CAL) begin
                r_offset <= r_neg ? -signed'(w_quo[31:0]) : signed'(w_quo[31:0]);
            end
            if (w_done && r_op == DIV_FLT) begin
                r_filt <= w_fnew;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            r_op  <= i_cmd.op;
            r_neg <= w_neg;
        end
        if (i_cmd.go && i_cmd.op == DIV_GAIN) begin
            r_gmul <= {32'd0, w_pmag} * {32'd0, RECIP_1000};
        end
        if (w_done && r_op == DIV_FLT) begin
            r_v <= w_fadj[FRAC_BITS+31:FRAC_BITS];
        end
        if (i_cmd.mul) begin
            r_prod <= (r_v - r_offset) * i_gain;
        end
        if (r_gdone) begin
            r_tilt <= r_neg ? -signed'(w_gq) : signed'(w_gq);
        end
    end

    assign w_tilt  = r_tilt - i_comp;
    assign o_tilt  = w_tilt;
    assign o_alarm = (w_tilt < i_alarm_lo) || (w_tilt > i_alarm_hi);
    assign o_done  = w_done || r_gdone;

endmodule

@@ sv/inclinometer_conditioning.sv @@
// ----------------------------------------------------------------------------
// inclinometer_conditioning
// dual-axis tilt conditioning: auto-zero, filter, calibration, alarms
// ----------------------------------------------------------------------------
// requests enter on i_req_valid / o_req_ready, results leave on
// o_rsp_valid / i_rsp_ready; settings are written over the apb port.
// only a sample tick gives a result; start calibration, load offsets and
// the unused action are absorbed.
// each axis has its own lane; a bit-serial divider handles the filter and
// the calibration mean, the division by 1000 is a reciprocal multiply.
// the tick that ends calibration also runs the 64-bit mean divide before
// the filter divide.
// one request is in flight at a time; a new one is taken only when the
// last one is finished.
// the result sits in an output register; a new request is taken while it
// waits, and the next tick stalls only at its final step until the
// previous result is taken.
// reset clears filter state, offsets, calibration state and settings to
// their defaults; no result is pending after reset.
// ----------------------------------------------------------------------------
module inclinometer_conditioning #(
    parameter longint unsigned CAL_PERIOD_NS = 64'd1000000000
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  ic_pkg::t_req  i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output ic_pkg::t_rsp  o_rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import ic_pkg::*;

    logic [2:0]         r_k;
    logic signed [31:0] r_gain_x, r_gain_y;
    logic signed [31:0] r_lo_x, r_hi_x, r_lo_y, r_hi_y;
    logic               r_tce;

    t_state             r_state, n_state;
    t_req               r_req;
    logic               r_cal_active;
    logic [63:0]        r_cal_elapsed;
    logic [31:0]        r_cal_count;
    logic signed [31:0] r_comp;
    logic               r_rsp_valid;
    t_rsp               r_rsp;

    t_lane_cmd          w_cmd;
    t_reg_idx           w_idx;
    logic               w_wr;
    logic [63:0]        w_el;
    logic [31:0]        w_cnt;
    logic               w_tick;
    logic               w_fin;
    logic signed [15:0] w_dt;
    logic [16:0]        w_dmag;
    logic [RECIP_SH+16:0] w_qprod;
    logic [16:0]        w_q;
    logic signed [31:0] w_c;
    logic               w_done_x, w_done_y;
    logic signed [31:0] w_tilt_x, w_tilt_y;
    logic               w_alarm_x, w_alarm_y;
    logic               w_out_go;

    // configuration port
    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_gain_x <= 32'sd1000;
            r_gain_y <= 32'sd1000;
            r_lo_x   <= 32'h8000_0000;
            r_hi_x   <= 32'h7fff_ffff;
            r_lo_y   <= 32'h8000_0000;
            r_hi_y   <= 32'h7fff_ffff;
            r_tce    <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_FILTER_STRENGTH:  r_k      <= pwdata[2:0];
                REG_GAIN_X:           r_gain_x <= pwdata;
                REG_GAIN_Y:           r_gain_y <= pwdata;
                REG_ALARM_LOW_X:      r_lo_x   <= pwdata;
                REG_ALARM_HIGH_X:     r_hi_x   <= pwdata;
                REG_ALARM_LOW_Y:      r_lo_y   <= pwdata;
                REG_ALARM_HIGH_Y:     r_hi_y   <= pwdata;
                REG_TEMP_COMP_ENABLE: r_tce    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FILTER_STRENGTH:  prdata = {29'd0, r_k};
            REG_GAIN_X:           prdata = r_gain_x;
            REG_GAIN_Y:           prdata = r_gain_y;
            REG_ALARM_LOW_X:      prdata = r_lo_x;
            REG_ALARM_HIGH_X:     prdata = r_hi_x;
            REG_ALARM_LOW_Y:      prdata = r_lo_y;
            REG_ALARM_HIGH_Y:     prdata = r_hi_y;
            REG_TEMP_COMP_ENABLE: prdata = {31'd0, r_tce};
            default:              prdata = '0;
        endcase
    end

    // calibration timing, shared by both lanes
    assign w_tick = (r_req.action == ACT_TICK);
    assign w_el   = r_cal_elapsed + 64'(r_req.elapsed_ns);
    assign w_cnt  = r_cal_count + 32'd1;
    assign w_fin  = r_cal_active && (w_el >= CAL_PERIOD_NS) && (w_cnt != 32'd0);

    // temperature compensation term, (t - 250) / 10 toward zero
    assign w_dt    = r_req.temperature - 16'(TEMP_REF);
    assign w_dmag  = w_dt[15] ? 17'(-w_dt) : 17'(w_dt);
    assign w_qprod = (RECIP_SH+17)'(w_dmag) * (RECIP_SH+17)'(RECIP_10);
    assign w_q     = w_qprod[RECIP_SH+16:RECIP_SH];
    assign w_c     = w_dt[15] ? -32'(w_q) : 32'(w_q);

    assign w_out_go = !r_rsp_valid || i_rsp_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_req_valid) n_state = ST_ACC;
            ST_ACC: begin
                if (!w_tick)    n_state = ST_IDLE;
                else if (w_fin) n_state = ST_CAL_GO;
                else            n_state = ST_FLT_GO;
            end
            ST_CAL_GO:    n_state = ST_CAL_WAIT;
            ST_CAL_WAIT:  if (w_done_x && w_done_y) n_state = ST_FLT_GO;
            ST_FLT_GO:    n_state = ST_FLT_WAIT;
            ST_FLT_WAIT:  if (w_done_x && w_done_y) n_state = ST_MUL;
            ST_MUL:       n_state = ST_GAIN_GO;
            ST_GAIN_GO:   n_state = ST_GAIN_WAIT;
            ST_GAIN_WAIT: if (w_done_x && w_done_y) n_state = ST_OUT;
            ST_OUT:       if (w_out_go) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // lane commands
    always_comb begin
        w_cmd = '{clr: 1'b0, acc: 1'b0, load: 1'b0, go: 1'b0, op: DIV_CAL, mul: 1'b0};
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: o_req_ready = 1'b1;
            ST_ACC: begin
                w_cmd.clr  = (r_req.action == ACT_CAL_START);
                w_cmd.load = (r_req.action == ACT_LOAD);
                w_cmd.acc  = w_tick && r_cal_active;
            end
            ST_CAL_GO: begin
                w_cmd.go = 1'b1;
                w_cmd.op = DIV_CAL;
            end
            ST_FLT_GO: begin
                w_cmd.go = 1'b1;
                w_cmd.op = DIV_FLT;
            end
            ST_MUL:     w_cmd.mul = 1'b1;
            ST_GAIN_GO: begin
                w_cmd.go = 1'b1;
                w_cmd.op = DIV_GAIN;
            end
            ST_CAL_WAIT:  w_cmd.op = DIV_CAL;
            ST_FLT_WAIT:  w_cmd.op = DIV_FLT;
            ST_GAIN_WAIT: w_cmd.op = DIV_GAIN;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cal_active  <= 1'b0;
            r_cal_elapsed <= '0;
            r_cal_count   <= '0;
            r_rsp_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ACC) begin
                if (r_req.action == ACT_CAL_START) begin
                    r_cal_active  <= 1'b1;
                    r_cal_elapsed <= '0;
                    r_cal_count   <= '0;
                end else if (w_tick && r_cal_active) begin
                    r_cal_elapsed <= w_el;
                    r_cal_count   <= w_cnt;
                    if (w_fin) r_cal_active <= 1'b0;
                end
            end
            if (r_state == ST_OUT && w_out_go) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_req_valid) r_req <= i_req;
        if (r_state == ST_ACC) r_comp <= r_tce ? w_c : 32'sd0;
        if (r_state == ST_OUT && w_out_go) begin
            r_rsp.tilt_x      <= w_tilt_x;
            r_rsp.tilt_y      <= w_tilt_y;
            r_rsp.alarm_x     <= w_alarm_x;
            r_rsp.alarm_y     <= w_alarm_y;
            r_rsp.calibrating <= r_cal_active;
        end
    end

    ic_lane u_lane_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_raw      (r_req.raw_x),
        .i_k        (r_k),
        .i_gain     (r_gain_x),
        .i_count    (r_cal_count),
        .i_comp     (r_comp),
        .i_alarm_lo (r_lo_x),
        .i_alarm_hi (r_hi_x),
        .o_done     (w_done_x),
        .o_tilt     (w_tilt_x),
        .o_alarm    (w_alarm_x)
    );

    ic_lane u_lane_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_raw      (r_req.raw_y),
        .i_k        (r_k),
        .i_gain     (r_gain_y),
        .i_count    (r_cal_count),
        .i_comp     (r_comp),
        .i_alarm_lo (r_lo_y),
        .i_alarm_hi (r_hi_y),
        .o_done     (w_done_y),
        .o_tilt     (w_tilt_y),
        .o_alarm    (w_alarm_y)
    );

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

@@ sv/ic_checker.sv @@
// ----------------------------------------------------------------------------
// ic_checker
// port-level checks of the inclinometer conditioning block
// ----------------------------------------------------------------------------
module ic_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_req_valid,
    input logic         o_req_ready,
    input ic_pkg::t_req i_req,
    input logic         o_rsp_valid,
    input logic         i_rsp_ready,
    input ic_pkg::t_rsp o_rsp,
    input logic         pready
);
    import ic_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while another is in flight");

    a_no_early_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready && i_req.action == ACT_TICK && !o_rsp_valid
        |=> !o_rsp_valid)
        else $error("result appeared too soon after a tick");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("result pending after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind inclinometer_conditioning ic_checker u_ic_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for inclinometer_conditioning: queued requests are
// driven with random gaps, every accepted request is predicted, and each
// result is compared field by field under several register settings
// ----------------------------------------------------------------------------
module tb;
    import ic_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_req_valid;
    logic        o_req_ready;
    t_req        i_req;
    logic        o_rsp_valid;
    logic        i_rsp_ready;
    t_rsp        o_rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    inclinometer_conditioning u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_ready(o_req_ready), .i_req(i_req),
        .o_rsp_valid(o_rsp_valid), .i_rsp_ready(i_rsp_ready), .o_rsp(o_rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    t_req pending_reqs[$];
    t_rsp expected_tilt[$];
    int   errors = 0;
    int   cycles = 0;
    bit   idle_on = 1'b1;
    bit   req_fire = 1'b0;
    int   req_gap = 0;
    int   rsp_hold = 0;

    // shadow of settings and state
    int      m_k;
    int      m_gx, m_gy, m_alx, m_ahx, m_aly, m_ahy;
    bit      m_tce;
    longint  m_fx, m_fy;
    int      m_ox, m_oy;
    bit      m_cal;
    longint unsigned m_elapsed;
    longint  m_sx, m_sy;
    int unsigned m_cnt;

    function automatic int calib_axis(int v, int off, int g);
        logic [31:0] d;
        logic [31:0] p;
        d = v - off;
        p = d * g;
        return $signed(p) / 1000;
    endfunction

    task automatic predict_tilt(t_req r);
        t_rsp e;
        int   vx, vy, d, c;
        if (r.action == ACT_CAL_START) begin
            m_cal = 1'b1;
            m_elapsed = 0;
            m_sx = 0;
            m_sy = 0;
            m_cnt = 0;
        end else if (r.action == ACT_LOAD) begin
            m_ox = r.raw_x;
            m_oy = r.raw_y;
        end else if (r.action == ACT_TICK) begin
            if (m_cal) begin
                m_elapsed += r.elapsed_ns;
                m_sx += longint'(r.raw_x);
                m_sy += longint'(r.raw_y);
                m_cnt += 1;
                if (m_elapsed >= 64'd1000000000 && m_cnt != 0) begin
                    m_ox = int'(m_sx / longint'(m_cnt));
                    m_oy = int'(m_sy / longint'(m_cnt));
                    m_cal = 1'b0;
                end
            end
            m_fx = (longint'(r.raw_x) * 256 + longint'(m_k) * m_fx) / longint'(1 + m_k);
            m_fy = (longint'(r.raw_y) * 256 + longint'(m_k) * m_fy) / longint'(1 + m_k);
            vx = int'(m_fx / 256);
            vy = int'(m_fy / 256);
            vx = calib_axis(vx, m_ox, m_gx);
            vy = calib_axis(vy, m_oy, m_gy);
            if (m_tce) begin
                d = int'(r.temperature) - 250;
                if (d < -32768) d += 65536;
                c = d * 10 / 100;
                vx = vx - c;
                vy = vy - c;
            end
            e.tilt_x = vx;
            e.tilt_y = vy;
            e.alarm_x = (vx < m_alx) || (vx > m_ahx);
            e.alarm_y = (vy < m_aly) || (vy > m_ahy);
            e.calibrating = m_cal;
            expected_tilt.push_back(e);
        end
    endtask

    // request accept and prediction
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
        req_fire <= i_req_valid && o_req_ready;
        if (i_rst_n && i_req_valid && o_req_ready) predict_tilt(i_req);
    end

    // result check
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (expected_tilt.size() == 0) begin
                $error("unexpected result tilt_x %0d", o_rsp.tilt_x);
                errors++;
            end else begin
                e = expected_tilt.pop_front();
                if (o_rsp.tilt_x !== e.tilt_x) begin
                    $error("tilt_x expected %0d actual %0d", e.tilt_x, o_rsp.tilt_x);
                    errors++;
                end
                if (o_rsp.tilt_y !== e.tilt_y) begin
                    $error("tilt_y expected %0d actual %0d", e.tilt_y, o_rsp.tilt_y);
                    errors++;
                end
                if (o_rsp.alarm_x !== e.alarm_x) begin
                    $error("alarm_x expected %0d actual %0d", e.alarm_x, o_rsp.alarm_x);
                    errors++;
                end
                if (o_rsp.alarm_y !== e.alarm_y) begin
                    $error("alarm_y expected %0d actual %0d", e.alarm_y, o_rsp.alarm_y);
                    errors++;
                end
                if (o_rsp.calibrating !== e.calibrating) begin
                    $error("calibrating expected %0d actual %0d",
                           e.calibrating, o_rsp.calibrating);
                    errors++;
                end
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_req_valid || req_fire)) begin
            if (req_gap > 0) begin
                req_gap--;
                i_req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_req <= pending_reqs.pop_front();
                i_req_valid <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0) req_gap = $urandom_range(1, 9);
            end else begin
                i_req_valid <= 1'b0;
            end
        end
    end

    // result ready with stall bursts
    always @(negedge i_clk) begin
        if (rsp_hold > 0) begin
            rsp_hold--;
            i_rsp_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_hold = $urandom_range(0, 8);
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= 1'b1;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_FILTER_STRENGTH:  m_k = v[2:0];
            REG_GAIN_X:           m_gx = v;
            REG_GAIN_Y:           m_gy = v;
            REG_ALARM_LOW_X:      m_alx = v;
            REG_ALARM_HIGH_X:     m_ahx = v;
            REG_ALARM_LOW_Y:      m_aly = v;
            REG_ALARM_HIGH_Y:     m_ahy = v;
            REG_TEMP_COMP_ENABLE: m_tce = v[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_req_valid || expected_tilt.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_req mk_req(logic [1:0] a, logic [31:0] x, logic [31:0] y,
                                    logic [15:0] t, logic [31:0] dt);
        t_req r;
        r.action = a;
        r.raw_x = x;
        r.raw_y = y;
        r.temperature = t;
        r.elapsed_ns = dt;
        return r;
    endfunction

    function automatic logic [31:0] rand_raw();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom_range(0, 200000) - 100000;
        endcase
    endfunction

    function automatic logic [31:0] rand_limit(bit high);
        case ($urandom_range(0, 3))
            0: return high ? 32'h7fff_ffff : 32'h8000_0000;
            1: return $urandom;
            default: return high ? $urandom_range(0, 150000) : -$urandom_range(0, 150000);
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom_range(0, 3000) - 500;
        endcase
    endfunction

    function automatic t_req rand_tick(bit cal_pace);
        logic [31:0] dt;
        logic [15:0] t;
        dt = cal_pace ? $urandom_range(50000000, 400000000) : $urandom;
        t = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 800) - 200);
        return mk_req(ACT_TICK, rand_raw(), rand_raw(), t, dt);
    endfunction

    task automatic fill_phase(int n);
        int i;
        int sel;
        i = 0;
        while (i < n) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                // calibration run with random content
                pending_reqs.push_back(mk_req(ACT_CAL_START, $urandom, $urandom,
                                              16'($urandom), $urandom));
                repeat ($urandom_range(2, 8)) begin
                    pending_reqs.push_back(rand_tick(1'b1));
                    i++;
                end
            end else if (sel == 1) begin
                pending_reqs.push_back(mk_req(ACT_LOAD, rand_raw(), rand_raw(),
                                              16'($urandom), $urandom));
                i++;
            end else if (sel == 2) begin
                pending_reqs.push_back(mk_req(2'd3, $urandom, $urandom, 16'($urandom),
                                              $urandom));
            end else begin
                pending_reqs.push_back(rand_tick($urandom_range(0, 1)));
                i++;
            end
        end
    endtask

    initial begin
        int ph;
        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_req = '0;
        i_rsp_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        m_k = 0;
        m_gx = 1000;
        m_gy = 1000;
        m_alx = 32'h8000_0000;
        m_ahx = 32'h7fff_ffff;
        m_aly = 32'h8000_0000;
        m_ahy = 32'h7fff_ffff;
        m_tce = 1'b0;
        m_fx = 0;
        m_fy = 0;
        m_ox = 0;
        m_oy = 0;
        m_cal = 1'b0;
        m_elapsed = 0;
        m_sx = 0;
        m_sy = 0;
        m_cnt = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes at reset settings
        pending_reqs.push_back(mk_req(ACT_TICK, 32'h7fff_ffff, 32'h8000_0000, 16'h7fff, 0));
        pending_reqs.push_back(mk_req(ACT_TICK, 32'h8000_0000, 32'h7fff_ffff, 16'h8000,
                                      32'hffff_ffff));
        pending_reqs.push_back(mk_req(ACT_TICK, 0, 32'hffff_ffff, 0, 1));
        pending_reqs.push_back(mk_req(2'd3, 32'hffff_ffff, 32'hffff_ffff, 16'hffff,
                                      32'hffff_ffff));
        pending_reqs.push_back(mk_req(ACT_LOAD, 32'h8000_0000, 32'h7fff_ffff, 0, 0));
        pending_reqs.push_back(mk_req(ACT_TICK, 32'h7fff_ffff, 32'h8000_0000, 0, 0));
        pending_reqs.push_back(mk_req(ACT_LOAD, 32'h7fff_ffff, 32'h8000_0000, 0, 0));
        pending_reqs.push_back(mk_req(ACT_TICK, 32'h8000_0000, 32'h7fff_ffff, 0, 0));
        // calibration ended by one long tick, then restarted mid run
        pending_reqs.push_back(mk_req(ACT_CAL_START, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(ACT_TICK, -7, 9, 250, 32'hffff_ffff));
        pending_reqs.push_back(mk_req(ACT_CAL_START, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(ACT_TICK, 32'h8000_0000, 32'h7fff_ffff, 0, 600000000));
        pending_reqs.push_back(mk_req(ACT_CAL_START, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(ACT_TICK, -5, 5, 0, 999999999));
        pending_reqs.push_back(mk_req(ACT_LOAD, 3, -3, 0, 0));
        pending_reqs.push_back(mk_req(ACT_TICK, -6, 6, 0, 1));
        pending_reqs.push_back(mk_req(ACT_TICK, 100, -100, 0, 0));
        wait_drained();

        // extreme settings with temperature compensation
        write_reg(REG_FILTER_STRENGTH, 7);
        write_reg(REG_GAIN_X, 32'h8000_0000);
        write_reg(REG_GAIN_Y, 32'h7fff_ffff);
        write_reg(REG_ALARM_LOW_X, 0);
        write_reg(REG_ALARM_HIGH_X, 0);
        write_reg(REG_ALARM_LOW_Y, 32'h7fff_ffff);
        write_reg(REG_ALARM_HIGH_Y, 32'h8000_0000);
        write_reg(REG_TEMP_COMP_ENABLE, 1);
        pending_reqs.push_back(mk_req(ACT_TICK, 32'h7fff_ffff, 32'h8000_0000, 16'h8000, 0));
        pending_reqs.push_back(mk_req(ACT_TICK, 32'h8000_0000, 32'h7fff_ffff, 16'h7fff, 0));
        pending_reqs.push_back(mk_req(ACT_TICK, 1, -1, 250, 0));
        pending_reqs.push_back(mk_req(ACT_TICK, 0, 0, 16'hffff, 0));
        wait_drained();

        for (ph = 0; ph < 8; ph++) begin
            if (ph == 7) idle_on = 1'b0;
            write_reg(REG_FILTER_STRENGTH, (ph == 0) ? 0 : (ph == 1) ? 7 : $urandom_range(0, 7));
            write_reg(REG_GAIN_X, rand_gain());
            write_reg(REG_GAIN_Y, rand_gain());
            write_reg(REG_ALARM_LOW_X, rand_limit(1'b0));
            write_reg(REG_ALARM_HIGH_X, rand_limit(1'b1));
            write_reg(REG_ALARM_LOW_Y, rand_limit(1'b0));
            write_reg(REG_ALARM_HIGH_Y, rand_limit(1'b1));
            write_reg(REG_TEMP_COMP_ENABLE, $urandom_range(0, 1));
            fill_phase(170);
            wait_drained();
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
